### src/lcdts_pkg.sv
// ----------------------------------------------------------------------------
// lcdts_pkg
// Shared constants, datapath operation codes and the command and status
// words between the controller and the datapath of the LCD text sequencer.
// ----------------------------------------------------------------------------
package lcdts_pkg;

	localparam int COLUMNS_DEF = 16;
	localparam int MAX_RESULTS = 32;

	// display instructions
	localparam logic [7:0] CMD_ROW0_HOME = 8'h80;
	localparam logic [7:0] CMD_ROW1_HOME = 8'hC0;
	localparam logic [7:0] CMD_LEFT      = 8'h10;
	localparam logic [7:0] CMD_RIGHT     = 8'h14;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;

	// text control characters
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_BS    = 8'h08;
	localparam logic [7:0] CHR_FF    = 8'h0C;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	// one datapath operation emits at most one word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_HOME_ROW,
		OP_JUMP_ROW,
		OP_RIGHT,
		OP_LEFT,
		OP_PRINT,
		OP_SPACE,
		OP_CLEAR,
		OP_RETURN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   char_load;
		logic   prev_load;
		logic   outer_load;
		logic   outer_dec;
		logic   inner_load;
		logic   inner_dec;
		logic   flush;
	} dp_cmd_t;

	typedef struct packed {
		logic can_step;
		logic col_zero;
		logic col_full;
		logic row;
		logic prev_lf;
		logic prev_cr;
		logic outer_zero;
		logic inner_zero;
		logic is_cr;
		logic is_lf;
		logic is_bs;
		logic is_ff;
	} dp_status_t;

endpackage

### src/lcdts_datapath.sv
// ----------------------------------------------------------------------------
// lcdts_datapath
// Cursor row and column, previous character, move counters, and the
// pending and output word registers that mark the last word of a run.
// ----------------------------------------------------------------------------
module lcdts_datapath import lcdts_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] character,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_data,
	output logic [7:0] code_byte,
	output logic       last
);

	localparam int COL_W = $clog2(COLUMNS + 1);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

	logic [7:0]       char_q;
	logic [7:0]       prev_q;
	logic             row_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] outer_q;
	logic [COL_W-1:0] inner_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_v_q;
	logic             pend_data_q;
	logic [7:0]       pend_code_q;
	logic             out_v_q;
	logic             out_data_q;
	logic [7:0]       out_code_q;
	logic             out_last_q;

	logic       em_v;
	logic       em_data;
	logic [7:0] em_code;
	logic       emit;
	logic       out_free;
	logic       push;

	always_comb begin
		em_v    = 1'b1;
		em_data = 1'b0;
		em_code = CMD_RIGHT;
		unique case (cmd.op)
			OP_NONE:     em_v = 1'b0;
			OP_HOME_ROW: em_code = row_q ? CMD_ROW1_HOME : CMD_ROW0_HOME;
			OP_JUMP_ROW: em_code = row_q ? CMD_ROW0_HOME : CMD_ROW1_HOME;
			OP_RIGHT:    em_code = CMD_RIGHT;
			OP_LEFT:     em_code = CMD_LEFT;
			OP_PRINT: begin
				em_data = 1'b1;
				em_code = char_q;
			end
			OP_SPACE: begin
				em_data = 1'b1;
				em_code = CHR_SPACE;
			end
			OP_CLEAR:    em_code = CMD_CLEAR;
			OP_RETURN:   em_code = CMD_HOME;
			default:     em_v = 1'b0;
		endcase
	end

	// words past the run limit are dropped, the cursor still follows
	assign emit     = em_v && (cnt_q != CNT_MAX);
	assign out_free = !out_v_q || out_ready;
	assign push     = pend_v_q && (emit || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= 1'b0;
			col_q    <= '0;
			prev_q   <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.prev_load)
				prev_q <= char_q;

			if (cmd.char_load)
				cnt_q <= '0;
			else if (emit)
				cnt_q <= cnt_q + CNT_W'(1);

			unique case (cmd.op)
				OP_HOME_ROW: col_q <= '0;
				OP_JUMP_ROW: begin
					row_q <= !row_q;
					col_q <= '0;
				end
				OP_RIGHT, OP_PRINT, OP_SPACE: col_q <= col_q + COL_W'(1);
				OP_LEFT:     col_q <= col_q - COL_W'(1);
				OP_RETURN: begin
					row_q <= 1'b0;
					col_q <= '0;
				end
				default: ;
			endcase

			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			if (push)
				out_v_q <= 1'b1;

			if (emit)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.char_load)
			char_q <= character;
		if (cmd.outer_load)
			outer_q <= COL_MAX;
		else if (cmd.outer_dec)
			outer_q <= outer_q - COL_W'(1);
		if (cmd.inner_load)
			inner_q <= COL_LAST;
		else if (cmd.inner_dec)
			inner_q <= inner_q - COL_W'(1);
		if (emit) begin
			pend_data_q <= em_data;
			pend_code_q <= em_code;
		end
		if (push) begin
			out_data_q <= pend_data_q;
			out_code_q <= pend_code_q;
			out_last_q <= cmd.flush;
		end
	end

	assign status.can_step   = !pend_v_q || out_free;
	assign status.col_zero   = (col_q == '0);
	assign status.col_full   = (col_q >= COL_MAX);
	assign status.row        = row_q;
	assign status.prev_lf    = (prev_q == CHR_LF);
	assign status.prev_cr    = (prev_q == CHR_CR);
	assign status.outer_zero = (outer_q == '0);
	assign status.inner_zero = (inner_q == '0);
	assign status.is_cr      = (char_q == CHR_CR);
	assign status.is_lf      = (char_q == CHR_LF);
	assign status.is_bs      = (char_q == CHR_BS);
	assign status.is_ff      = (char_q == CHR_FF);

	assign out_valid = out_v_q;
	assign is_data   = out_data_q;
	assign code_byte = out_code_q;
	assign last      = out_last_q;

endmodule

### src/lcdts_ctrl.sv
// ----------------------------------------------------------------------------
// lcdts_ctrl
// Sequencer that expands one character into datapath operations:
// homing, row walks for newline, left moves with row jump, backspace,
// clear and printable output.
// ----------------------------------------------------------------------------
module lcdts_ctrl import lcdts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LF_LOOP,
		S_LEFT,
		S_WALK,
		S_PRINT,
		S_FF_HOME,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   dir_right_q, dir_right_d;
	logic   bs_q, bs_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NONE;
		state_d     = state_q;
		ret_d       = ret_q;
		dir_right_d = dir_right_q;
		bs_d        = bs_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.char_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.can_step) begin
					cmd.prev_load = 1'b1;
					bs_d          = status.is_bs;
					priority if (status.is_cr) begin
						if (!status.prev_lf)
							cmd.op = OP_HOME_ROW;
						state_d = S_FLUSH;
					end else if (status.is_lf) begin
						// CRLF and LFCR home only once
						if (!status.prev_cr)
							cmd.op = OP_HOME_ROW;
						dir_right_d    = !status.row;
						cmd.outer_load = 1'b1;
						state_d        = S_LF_LOOP;
					end else if (status.is_bs) begin
						ret_d   = S_PRINT;
						state_d = S_LEFT;
					end else if (status.is_ff) begin
						cmd.op  = OP_CLEAR;
						state_d = S_FF_HOME;
					end else begin
						state_d = S_PRINT;
					end
				end
			end
			S_LF_LOOP: begin
				if (status.can_step) begin
					if (dir_right_q) begin
						// a right move that fills the row jumps before the next one
						if (status.col_full)
							cmd.op = OP_JUMP_ROW;
						else if (status.outer_zero)
							state_d = S_FLUSH;
						else begin
							cmd.op        = OP_RIGHT;
							cmd.outer_dec = 1'b1;
						end
					end else begin
						if (status.outer_zero)
							state_d = S_FLUSH;
						else begin
							cmd.outer_dec = 1'b1;
							ret_d         = S_LF_LOOP;
							state_d       = S_LEFT;
						end
					end
				end
			end
			S_LEFT: begin
				if (status.can_step) begin
					if (status.col_zero) begin
						// left from column zero: other row, then walk to its last cell
						cmd.op         = OP_JUMP_ROW;
						cmd.inner_load = 1'b1;
						state_d        = S_WALK;
					end else begin
						cmd.op  = OP_LEFT;
						state_d = ret_q;
					end
				end
			end
			S_WALK: begin
				if (status.can_step) begin
					if (status.inner_zero)
						state_d = ret_q;
					else begin
						cmd.op        = OP_RIGHT;
						cmd.inner_dec = 1'b1;
					end
				end
			end
			S_PRINT: begin
				if (status.can_step) begin
					if (status.col_full)
						cmd.op = OP_JUMP_ROW;
					else if (bs_q) begin
						cmd.op  = OP_SPACE;
						ret_d   = S_FLUSH;
						state_d = S_LEFT;
					end else begin
						cmd.op  = OP_PRINT;
						state_d = S_FLUSH;
					end
				end
			end
			S_FF_HOME: begin
				if (status.can_step) begin
					cmd.op  = OP_RETURN;
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (status.can_step) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_FLUSH;
			dir_right_q <= 1'b0;
			bs_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			dir_right_q <= dir_right_d;
			bs_q        <= bs_d;
		end
	end

endmodule

### src/char_lcd_text_cursor_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_sequencer
// Two-row character LCD text sequencer: each text character becomes a run
// of instruction and data words, tracking cursor row, column and the
// previous character.
// ----------------------------------------------------------------------------
// the first word of a run waits in the pending register and moves to the
//   output register when the next word is emitted or the run is flushed
// one character is handled at a time; a left move from column zero walks the
//   other row to its last cell, a newline on row 1 is made of left moves, and
//   the sequencer steps one move a cycle while the output can take words
// the next character is taken while the last word of a run still waits
// reset: asynchronous, cursor at row 0 column 0, previous character zero
module char_lcd_text_cursor_sequencer import lcdts_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_data,
	output logic [7:0] code_byte,
	output logic       last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	lcdts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdts_datapath #(
		.COLUMNS (COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.character (character),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_data   (is_data),
		.code_byte (code_byte),
		.last      (last)
	);

endmodule
